// ===== src/afrg_pkg.sv =====
// ---------------------------------------------------------------------------
// afrg_pkg
// shared types and constants for the additive feedback random generator
// ---------------------------------------------------------------------------
`default_nettype none

package afrg_pkg;

  // default geometry
  localparam int DEGREE_DEF        = 31;
  localparam int SEPARATION_DEF    = 3;
  localparam int WARMUP_FACTOR_DEF = 10;

  localparam int WORD_W = 32;

  // park-miller / schrage constants
  localparam int PROD_W = 34;
  localparam int REM_W  = 17;
  localparam int QUOT_W = 16;

  localparam logic [REM_W:0]               PM_Q     = 18'd127773;
  localparam logic signed [PROD_W-1:0]     PM_MUL   = 34'sd16807;
  localparam logic signed [PROD_W-1:0]     PM_R     = 34'sd2836;
  localparam logic signed [PROD_W-1:0]     PM_MOD   = 34'sd2147483647;

  // divide by q as a multiply by its rounded-up reciprocal; exact for
  // dividends up to 2^31 since the rounding error times 2^31 stays below 2^48
  localparam int RECIP_SHIFT = 48;
  localparam logic [WORD_W-1:0] PM_Q_RECIP =
    WORD_W'(((64'd1 << RECIP_SHIFT) + 64'(PM_Q) - 64'd1) / 64'(PM_Q));

  // item opcodes
  localparam logic OP_NEXT = 1'b0;
  localparam logic OP_SEED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_WR,
    ST_SEED_DIV,
    ST_SEED_MUL,
    ST_SEED_SUB,
    ST_SEED_FIX,
    ST_STEP_READ,
    ST_STEP_ADD
  } afrg_state_t;

endpackage

`default_nettype wire

// ===== src/afrg_divq.sv =====
// ---------------------------------------------------------------------------
// afrg_divq
// divide by the schrage constant q through a reciprocal multiply, registered
// ---------------------------------------------------------------------------
`default_nettype none

module afrg_divq (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [afrg_pkg::WORD_W-1:0] dividend,
  output logic                             done,
  output logic [afrg_pkg::QUOT_W-1:0]      quot,
  output logic [afrg_pkg::REM_W-1:0]       rem
);
  import afrg_pkg::*;

  localparam int MUL_W = 2 * WORD_W;

  logic              pend;    // product stage holds a dividend
  logic [MUL_W-1:0]  prod;
  logic [WORD_W-1:0] dvd;
  logic [QUOT_W-1:0] q_est;
  logic [WORD_W-1:0] back;

  assign q_est = prod[RECIP_SHIFT +: QUOT_W];
  assign back  = dvd - WORD_W'(q_est) * WORD_W'(PM_Q);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      pend <= start;
      done <= pend;
    end
  end

  // the product register takes the multiply, the output registers take the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= MUL_W'(dividend) * MUL_W'(PM_Q_RECIP);
      dvd  <= dividend;
    end
    if (pend) begin
      quot <= q_est;
      rem  <= REM_W'(back);
    end
  end

endmodule

`default_nettype wire

// ===== src/afrg_ring.sv =====
// ---------------------------------------------------------------------------
// afrg_ring
// ring word memory, one write port and two registered read ports
// ---------------------------------------------------------------------------
`default_nettype none

module afrg_ring #(
  parameter int DEPTH  = afrg_pkg::DEGREE_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [ADDR_W-1:0]           waddr,
  input  wire logic [afrg_pkg::WORD_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]           raddr_a,
  input  wire logic [ADDR_W-1:0]           raddr_b,
  output logic [afrg_pkg::WORD_W-1:0]      rdata_a,
  output logic [afrg_pkg::WORD_W-1:0]      rdata_b
);
  import afrg_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== src/additive_feedback_random_generator.sv =====
// ---------------------------------------------------------------------------
// additive_feedback_random_generator
// additive lagged fibonacci generator with park-miller seeding and warmup
// ---------------------------------------------------------------------------
//
//  channel   signals                         direction  handshake
//  -------   ------------------------------  ---------  -------------------
//  command   start, opcode, seed, busy       in         start high, busy low
//  result    done, value                     out        done for one cycle
//
// a next item holds busy through a ring read state, then an add and write-back state;
//   done rises in the cycle after the add state; before the first seed a next item
//   gives value 0 in the following cycle with no busy time
// a seed item holds busy while each ring word is written and, but for the last,
//   passed through the reciprocal divide and the schrage multiply, subtract
//   and fold states, and then through the ring read/add loop of the warmup
// rst is synchronous; after it the generator is unseeded
// the result side cannot stall: value is valid only while done is high
// ---------------------------------------------------------------------------
`default_nettype none

module additive_feedback_random_generator #(
  parameter int DEGREE        = afrg_pkg::DEGREE_DEF,
  parameter int SEPARATION    = afrg_pkg::SEPARATION_DEF,
  parameter int WARMUP_FACTOR = afrg_pkg::WARMUP_FACTOR_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        opcode,
  input  wire logic [31:0] seed,
  output logic             done,
  output logic [30:0]      value
);
  import afrg_pkg::*;

  localparam int IDX_W     = $clog2(DEGREE);
  localparam int SEP_MOD   = SEPARATION % DEGREE;
  localparam int WARM_N    = DEGREE * WARMUP_FACTOR;
  localparam int CNT_W     = $clog2(WARM_N + 2);

  // sequencer state
  afrg_state_t state, state_next;

  // ring pointers and status
  logic [IDX_W-1:0] front;
  logic [IDX_W-1:0] rear;
  logic             seeded;
  logic             warm;         // current step belongs to the warmup
  logic [CNT_W-1:0] warm_cnt;     // warmup steps still to run

  // seeding datapath
  logic [IDX_W-1:0]         widx;   // ring word being written
  logic signed [WORD_W-1:0] word;   // current park-miller word
  logic                     neg;
  logic signed [QUOT_W:0]   hi;
  logic signed [REM_W:0]    lo;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_fix;

  // ring memory hookup
  logic              ring_we;
  logic [IDX_W-1:0]  ring_waddr;
  logic [WORD_W-1:0] ring_wdata;
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;
  logic [WORD_W-1:0] sum;

  // divider hookup
  logic              div_start;
  logic [WORD_W-1:0] div_dividend;
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;
  logic [REM_W-1:0]  div_rem;

  logic              accept;
  logic [WORD_W-1:0] seed_fixed;
  logic              last_word;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  // a zero seed would lock the park-miller sequence at zero
  assign seed_fixed = (seed == '0) ? WORD_W'(1) : seed;
  assign last_word  = (widx == IDX_W'(DEGREE - 1));
  assign sum        = rdata_a + rdata_b;
  assign prod_fix   = prod + PM_MOD;

  // schrage works on the magnitude; sign is put back after the divide
  assign div_dividend = word[WORD_W-1] ? (~word + 1'b1) : word;

  afrg_ring #(
    .DEPTH  (DEGREE),
    .ADDR_W (IDX_W)
  ) u_ring (
    .clk     (clk),
    .we      (ring_we),
    .waddr   (ring_waddr),
    .wdata   (ring_wdata),
    .raddr_a (front),
    .raddr_b (rear),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  afrg_divq u_divq (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and ring/divider controls
  always_comb begin
    state_next = state;
    ring_we    = 1'b0;
    ring_waddr = front;
    ring_wdata = sum;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (opcode == OP_SEED) begin
            state_next = ST_SEED_WR;
          end else if (seeded) begin
            state_next = ST_STEP_READ;
          end
        end
      end
      ST_SEED_WR: begin
        ring_we    = 1'b1;
        ring_waddr = widx;
        ring_wdata = word;
        if (last_word) begin
          state_next = (WARM_N == 0) ? ST_IDLE : ST_STEP_READ;
        end else begin
          div_start  = 1'b1;
          state_next = ST_SEED_DIV;
        end
      end
      ST_SEED_DIV: begin
        if (div_done) begin
          state_next = ST_SEED_MUL;
        end
      end
      ST_SEED_MUL:  state_next = ST_SEED_SUB;
      ST_SEED_SUB:  state_next = ST_SEED_FIX;
      ST_SEED_FIX:  state_next = ST_SEED_WR;
      ST_STEP_READ: state_next = ST_STEP_ADD;
      ST_STEP_ADD: begin
        ring_we = 1'b1;
        if (warm && (warm_cnt != CNT_W'(1))) begin
          state_next = ST_STEP_READ;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      rear     <= '0;
      seeded   <= 1'b0;
      warm     <= 1'b0;
      warm_cnt <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept && (opcode == OP_NEXT)) begin
            warm <= 1'b0;
            // unseeded next answers at once with zero
            if (!seeded) begin
              done <= 1'b1;
            end
          end
        end
        ST_SEED_WR: begin
          if (last_word) begin
            front    <= IDX_W'(SEP_MOD);
            rear     <= '0;
            seeded   <= 1'b1;
            warm     <= 1'b1;
            warm_cnt <= CNT_W'(WARM_N);
          end
        end
        ST_STEP_ADD: begin
          front <= (front == IDX_W'(DEGREE - 1)) ? '0 : front + 1'b1;
          rear  <= (rear == IDX_W'(DEGREE - 1)) ? '0 : rear + 1'b1;
          if (warm) begin
            warm_cnt <= warm_cnt - 1'b1;
          end else begin
            done <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          word  <= seed_fixed;
          widx  <= '0;
          value <= '0;
        end
      end
      ST_SEED_WR: begin
        if (!last_word) begin
          widx <= widx + 1'b1;
        end
        neg <= word[WORD_W-1];
      end
      ST_SEED_DIV: begin
        if (div_done) begin
          hi <= neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
          lo <= neg ? -$signed({1'b0, div_rem}) : $signed({1'b0, div_rem});
        end
      end
      ST_SEED_MUL: prod <= PM_MUL * PROD_W'(lo);
      ST_SEED_SUB: prod <= prod - PM_R * PROD_W'(hi);
      ST_SEED_FIX: begin
        // fold a negative result back into the modulus range
        word <= prod[PROD_W-1] ? prod_fix[WORD_W-1:0] : prod[WORD_W-1:0];
      end
      ST_STEP_ADD: begin
        value <= sum[WORD_W-1:1];
      end
      default: ;
    endcase
  end

  // expected front pointer from the rear pointer and the lag
  logic [IDX_W:0]   lag_sum;
  logic [IDX_W-1:0] lag_front;

  assign lag_sum   = (IDX_W + 1)'(rear) + (IDX_W + 1)'(SEP_MOD);
  assign lag_front = (lag_sum >= (IDX_W + 1)'(DEGREE))
                   ? IDX_W'(lag_sum - (IDX_W + 1)'(DEGREE)) : lag_sum[IDX_W-1:0];

  // a seed item always starts a busy period
  a_seed_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode == OP_SEED)) |=> busy)
    else $error("seed item did not start the seeding sequence");

  // results before the first seed are zero
  a_unseeded_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !seeded) |-> (value == '0))
    else $error("unseeded result is not zero");

  // front stays ahead of rear by the lag while idle and seeded
  a_lag_kept: assert property (@(posedge clk) disable iff (rst)
    (seeded && (state == ST_IDLE)) |-> (front == lag_front))
    else $error("ring pointers lost their separation");

  // no result is produced in the divide, multiply and fold states of seeding
  a_no_result_seeding: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SEED_DIV) || (state == ST_SEED_MUL) || (state == ST_SEED_FIX))
      |-> !done)
    else $error("result strobe while seeding");

endmodule

`default_nettype wire
